// File: rtl/core/brs_pkg.sv
// Package for the 2D box range search block: command and result codes,
// the decoded work item and the result record. Depends on nothing.
`timescale 1ns / 1ps

package brs_pkg;

    // Widths of the fixed channel fields.
    localparam int FIELD_W = 32;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 6;

    // Command codes on the request channel.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // Result kinds on the result channel.
    localparam logic [KIND_W-1:0] KIND_ACK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HIT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUM = 2'd2;

    // Status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Depth of the queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Operation after decode.
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_ADD,
        OP_QUERY,
        OP_NOP
    } op_t;

    // Decoded request; coordinates are already reduced to the coordinate
    // width and sign-extended back to the field width.
    typedef struct packed {
        op_t                       op;
        logic                      box_empty;
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
        logic signed [FIELD_W-1:0] box_x_low;
        logic signed [FIELD_W-1:0] box_x_high;
        logic signed [FIELD_W-1:0] box_y_low;
        logic signed [FIELD_W-1:0] box_y_high;
    } work_t;

    // One result record.
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [FIELD_W-1:0] hit_x;
        logic signed [FIELD_W-1:0] hit_y;
        logic [COUNT_W-1:0]        match_count;
        logic                      found_any;
        logic                      status;
        logic                      last;
    } result_t;

    // Build a result record; found_any follows from the count.
    function automatic result_t make_result(
        input logic [KIND_W-1:0]         kind,
        input logic signed [FIELD_W-1:0] x,
        input logic signed [FIELD_W-1:0] y,
        input logic [COUNT_W-1:0]        cnt,
        input logic                      status,
        input logic                      last
    );
        result_t r;
        r.kind        = kind;
        r.hit_x       = x;
        r.hit_y       = y;
        r.match_count = cnt;
        r.found_any   = (cnt != '0);
        r.status      = status;
        r.last        = last;
        return r;
    endfunction

endpackage

// File: rtl/core/brs_in_if.sv
// Request channel of the box range search block: valid/ready plus the
// command and coordinate fields. Depends on brs_pkg.
`timescale 1ns / 1ps

interface brs_in_if;

    logic                                        valid;
    logic                                        ready;
    logic [brs_pkg::CMD_W-1:0]                   command;
    logic signed [brs_pkg::FIELD_W-1:0]          point_x;
    logic signed [brs_pkg::FIELD_W-1:0]          point_y;
    logic signed [brs_pkg::FIELD_W-1:0]          box_x_low;
    logic signed [brs_pkg::FIELD_W-1:0]          box_x_high;
    logic signed [brs_pkg::FIELD_W-1:0]          box_y_low;
    logic signed [brs_pkg::FIELD_W-1:0]          box_y_high;

    modport source (
        output valid, command, point_x, point_y,
               box_x_low, box_x_high, box_y_low, box_y_high,
        input  ready
    );

    modport sink (
        input  valid, command, point_x, point_y,
               box_x_low, box_x_high, box_y_low, box_y_high,
        output ready
    );

endinterface

// File: rtl/core/brs_out_if.sv
// Result channel of the box range search block: valid/ready plus the
// result fields. Depends on brs_pkg.
`timescale 1ns / 1ps

interface brs_out_if;

    logic                                valid;
    logic                                ready;
    logic [brs_pkg::KIND_W-1:0]          result_kind;
    logic signed [brs_pkg::FIELD_W-1:0]  hit_x;
    logic signed [brs_pkg::FIELD_W-1:0]  hit_y;
    logic [brs_pkg::COUNT_W-1:0]         match_count;
    logic                                found_any;
    logic                                status;
    logic                                last;

    modport source (
        output valid, result_kind, hit_x, hit_y, match_count,
               found_any, status, last,
        input  ready
    );

    modport sink (
        input  valid, result_kind, hit_x, hit_y, match_count,
               found_any, status, last,
        output ready
    );

endinterface

// File: rtl/core/brs_front.sv
// Front of the box range search block: takes requests, decodes the command,
// trims coordinates and flags empty boxes. Depends on brs_pkg, brs_in_if.
`timescale 1ns / 1ps

module brs_front #(
    parameter int COORD_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    brs_in_if.sink         request,
    output logic           item_valid,
    input  logic           item_ready,
    output brs_pkg::work_t item
);

    import brs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    work_t item_reg;
    work_t decoded;

    // Keep the low coordinate bits and sign-extend them to the field width.
    function automatic logic signed [FIELD_W-1:0] trim(input logic [FIELD_W-1:0] v);
        logic signed [COORD_BITS-1:0] t;
        t = v[COORD_BITS-1:0];
        return FIELD_W'(t);
    endfunction

    // Decode the request.
    always_comb
    begin
        decoded.point_x    = trim(request.point_x);
        decoded.point_y    = trim(request.point_y);
        decoded.box_x_low  = trim(request.box_x_low);
        decoded.box_x_high = trim(request.box_x_high);
        decoded.box_y_low  = trim(request.box_y_low);
        decoded.box_y_high = trim(request.box_y_high);
        decoded.box_empty  = (decoded.box_x_low > decoded.box_x_high) ||
                             (decoded.box_y_low > decoded.box_y_high);
        unique case (request.command)
            CMD_CLEAR: decoded.op = OP_CLEAR;
            CMD_ADD:   decoded.op = OP_ADD;
            CMD_QUERY: decoded.op = OP_QUERY;
            default:   decoded.op = OP_NOP;
        endcase
    end

    // The holding stage takes a new request whenever it is empty or drains.
    assign request.ready = !valid_reg || item_ready;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_comb
    begin
        valid_next = valid_reg && !item_ready;
        if (request.valid && request.ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            item_reg <= decoded;
        end
    end

endmodule

// File: rtl/core/brs_queue.sv
// Short queue of decoded requests between the front and the back of the
// box range search block. Depends on brs_pkg.
`timescale 1ns / 1ps

module brs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  brs_pkg::work_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output brs_pkg::work_t pop_item
);

    import brs_pkg::*;

    work_t             slots [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/core/brs_back.sv
// Back of the box range search block: owns the point store and the count,
// runs adds and clears, scans the store for queries and drives results.
// Depends on brs_pkg and brs_out_if.
`timescale 1ns / 1ps

module brs_back #(
    parameter int CAPACITY   = 32,
    parameter int COORD_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  brs_pkg::work_t q_item,
    brs_out_if.source      result
);

    import brs_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ST_W  = 1;
    localparam logic [ST_W-1:0] ST_IDLE = 1'b0;
    localparam logic [ST_W-1:0] ST_SCAN = 1'b1;

    logic [2*COORD_BITS-1:0]      store [CAPACITY];

    logic [ST_W-1:0]              state_reg;
    logic [ST_W-1:0]              state_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [CNT_W-1:0]             scan_reg;
    logic [CNT_W-1:0]             scan_next;
    logic [COUNT_W-1:0]           hits_reg;
    logic [COUNT_W-1:0]           hits_next;
    logic                         rd_valid_reg;
    logic                         rd_valid_next;
    logic [2*COORD_BITS-1:0]      rd_data_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    result_t                      out_reg;
    result_t                      out_next;
    logic signed [COORD_BITS-1:0] xl_reg;
    logic signed [COORD_BITS-1:0] xh_reg;
    logic signed [COORD_BITS-1:0] yl_reg;
    logic signed [COORD_BITS-1:0] yh_reg;

    logic                         mem_we;
    logic                         rd_en;
    logic                         box_load;
    logic                         out_free;
    logic                         store_full;
    logic                         issue;
    logic                         hit;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;

    assign out_free   = !out_valid_reg || result.ready;
    assign store_full = (count_reg == CNT_W'(CAPACITY));
    assign issue      = (scan_reg < count_reg);

    // Box test on the point held in the read register.
    assign px  = rd_data_reg[2*COORD_BITS-1:COORD_BITS];
    assign py  = rd_data_reg[COORD_BITS-1:0];
    assign hit = (px >= xl_reg) && (px <= xh_reg) && (py >= yl_reg) && (py <= yh_reg);

    // Command execution and scan control.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        hits_next      = hits_reg;
        rd_valid_next  = rd_valid_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_next       = out_reg;
        q_ready        = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        box_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_ready = 1'b1;
                    unique case (q_item.op)
                        OP_CLEAR:
                        begin
                            count_next     = '0;
                            out_valid_next = 1'b1;
                            out_next       = make_result(KIND_ACK, '0, '0, '0, STATUS_OK, 1'b1);
                        end
                        OP_ADD:
                        begin
                            out_valid_next = 1'b1;
                            if (store_full)
                            begin
                                out_next = make_result(KIND_ACK, '0, '0, '0, STATUS_FULL, 1'b1);
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                out_next   = make_result(KIND_ACK, '0, '0, '0, STATUS_OK, 1'b1);
                            end
                        end
                        OP_QUERY:
                        begin
                            if (q_item.box_empty)
                            begin
                                out_valid_next = 1'b1;
                                out_next = make_result(KIND_SUM, '0, '0, '0, STATUS_OK, 1'b1);
                            end
                            else
                            begin
                                box_load      = 1'b1;
                                scan_next     = '0;
                                hits_next     = '0;
                                rd_valid_next = 1'b0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_next       = make_result(KIND_ACK, '0, '0, '0, STATUS_OK, 1'b1);
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!rd_valid_reg && !issue)
                begin
                    // All points tested: close with the summary.
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next   = make_result(KIND_SUM, '0, '0, hits_reg, STATUS_OK, 1'b1);
                        state_next = ST_IDLE;
                    end
                end
                else if (!(rd_valid_reg && hit && !out_free))
                begin
                    // Read the next point while the current one is tested.
                    rd_en         = issue;
                    rd_valid_next = issue;
                    if (issue)
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                    if (rd_valid_reg && hit)
                    begin
                        out_valid_next = 1'b1;
                        out_next  = make_result(KIND_HIT, FIELD_W'(px), FIELD_W'(py), '0,
                                                STATUS_OK, 1'b0);
                        hits_next = hits_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            hits_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            hits_reg      <= hits_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload and query box.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (box_load)
        begin
            xl_reg <= q_item.box_x_low[COORD_BITS-1:0];
            xh_reg <= q_item.box_x_high[COORD_BITS-1:0];
            yl_reg <= q_item.box_y_low[COORD_BITS-1:0];
            yh_reg <= q_item.box_y_high[COORD_BITS-1:0];
        end
    end

    // Point store: one write port for adds, one registered read for scans.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[count_reg[IDX_W-1:0]] <= {q_item.point_x[COORD_BITS-1:0],
                                            q_item.point_y[COORD_BITS-1:0]};
        end
        if (rd_en)
        begin
            rd_data_reg <= store[scan_reg[IDX_W-1:0]];
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.result_kind = out_reg.kind;
    assign result.hit_x       = out_reg.hit_x;
    assign result.hit_y       = out_reg.hit_y;
    assign result.match_count = out_reg.match_count;
    assign result.found_any   = out_reg.found_any;
    assign result.status      = out_reg.status;
    assign result.last        = out_reg.last;

endmodule

// File: rtl/core/box_range_search_2d.sv
// Top level of the 2D box range search block: front, queue and back.
// Depends on brs_pkg, brs_in_if, brs_out_if, brs_front, brs_queue, brs_back.
//
// The block holds up to CAPACITY points with signed fixed-point coordinates
// (Q16.16 at COORD_BITS of 32; only the low COORD_BITS of each field count).
// Clear, add and unknown commands each give one acknowledge marked last; an
// add to a full store is acknowledged with status 1. A query gives one result
// per stored point inside its inclusive box, in insertion order, then a
// summary with the match count, marked last. A query takes the request,
// reads each stored point through the single read port of the point
// store, tests each point read while the next is read, and issues the
// summary. A result that the result channel holds back stalls the back
// until it is taken. A box that is inverted in either axis is answered
// at once with a zero summary. Requests pass through a one-entry front
// stage and a two-entry queue, so new requests are taken while a query
// scans. No clearing pass follows reset.
`timescale 1ns / 1ps

module box_range_search_2d #(
    parameter int CAPACITY   = 32,
    parameter int COORD_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    brs_in_if.sink    request,
    brs_out_if.source result
);

    import brs_pkg::*;

    logic  front_valid;
    logic  front_ready;
    work_t front_item;
    logic  back_valid;
    logic  back_ready;
    work_t back_item;

    // Decode and hold incoming requests.
    brs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    // Decouple the front from the scanning back.
    brs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    // Execute commands against the point store.
    brs_back #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (back_valid),
        .q_ready (back_ready),
        .q_item  (back_item),
        .result  (result)
    );

endmodule
